@@ sv/b64d_pkg.sv @@
// b64d_pkg: types, constants and the symbol table for the base64url decoder
// used by base64url_decoder; depends on nothing else

package b64d_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam logic [15:0] CAP_RESET      = 16'hFFFF;

  localparam logic [7:0] CHAR_TERM  = 8'h00;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_UNDER = 8'h5F;  // '_'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

  localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
  localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SYM_62         = 6'd62;
  localparam logic [5:0] SYM_63         = 6'd63;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_OVER_CAP  = 2'd2,
    ST_BAD_TRAIL = 2'd3
  } status_t;

  typedef struct packed {
    logic        ok;
    logic [5:0]  value;
  } sym_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_final;
    status_t     status;
    logic [15:0] byte_count;
  } result_t;

  function automatic sym_t symbol_value(input logic [7:0] c);
    sym_t s;
    s.ok    = 1'b1;
    s.value = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      s.value = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      s.value = 6'(c - CHAR_LOWER_A) + SYM_LOWER_BASE;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      s.value = 6'(c - CHAR_DIGIT_0) + SYM_DIGIT_BASE;
    end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
      s.value = SYM_62;
    end else if (c == CHAR_UNDER || c == CHAR_SLASH) begin
      s.value = SYM_63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ sv/base64url_decoder.sv @@
// base64url_decoder: streaming decoder, one character per transfer, bytes out
// depends on b64d_pkg
//
//   channel   signals                      direction  payload
//   in        in_valid / in_ready          input      char_code
//   out       out_valid / out_ready        output     out_byte, is_final, status, byte_count
//   cfg       cfg_we / cfg_data            input      output_capacity
//
// one character per cycle while in_ready is high; the decode state updates at the input
// transfer and the result lands the same edge in the output register, or in the skid
// entry while the output register waits; a two-entry output buffer lets input keep
// flowing while a result waits; in_ready drops only when both entries hold results
// rst clears decode state and buffers and sets the capacity to 65535

module base64url_decoder #(
  parameter int unsigned COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        is_final,
  output logic [1:0]  status,
  output logic [15:0] byte_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import b64d_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [15:0]           output_capacity;
  logic [11:0]           bit_accumulator, bit_accumulator_next;
  logic [3:0]            pending_bits, pending_bits_next;
  logic [COUNT_BITS-1:0] bytes_emitted, bytes_emitted_next;
  status_t               error_code, error_code_next;
  logic                  padding_seen, padding_seen_next;

  result_t out_reg, skid_reg, res;
  logic    skid_valid;
  logic    res_valid;
  logic    accept;

  sym_t        sym;
  logic [11:0] acc_shift;
  logic [3:0]  pend_sum, pend_left;
  logic [11:0] trail_mask;
  logic [11:0] byte_window;
  logic        cap_hit;
  status_t     final_status;

  assign accept   = in_valid && in_ready;
  assign in_ready = !skid_valid;

  assign sym         = symbol_value(char_code);
  assign acc_shift   = {bit_accumulator[5:0], sym.value};
  assign pend_sum    = pending_bits + 4'd6;
  assign pend_left   = pend_sum - 4'd8;
  assign byte_window = acc_shift >> pend_left;
  assign trail_mask  = (12'd1 << pending_bits) - 12'd1;
  assign cap_hit     = (CMP_W'(bytes_emitted) >= CMP_W'(output_capacity))
                    || (bytes_emitted == {COUNT_BITS{1'b1}});

  always_comb begin
    final_status = error_code;
    if (error_code == ST_OK) begin
      if (pending_bits >= 4'd6 || (bit_accumulator & trail_mask) != 12'd0) begin
        final_status = ST_BAD_TRAIL;
      end
    end
  end

  always_comb begin
    bit_accumulator_next = bit_accumulator;
    pending_bits_next    = pending_bits;
    bytes_emitted_next   = bytes_emitted;
    error_code_next      = error_code;
    padding_seen_next    = padding_seen;
    res_valid            = 1'b0;
    res                  = '0;
    if (char_code == CHAR_TERM) begin
      res_valid            = 1'b1;
      res.is_final         = 1'b1;
      res.status           = final_status;
      if (final_status == ST_OK) begin
        res.byte_count = 16'(bytes_emitted);
      end
      bit_accumulator_next = '0;
      pending_bits_next    = '0;
      bytes_emitted_next   = '0;
      error_code_next      = ST_OK;
      padding_seen_next    = 1'b0;
    end else if (error_code != ST_OK || padding_seen) begin
      // ignored until terminator
    end else if (char_code == CHAR_PAD) begin
      padding_seen_next = 1'b1;
    end else if (!sym.ok) begin
      error_code_next = ST_BAD_CHAR;
    end else begin
      bit_accumulator_next = acc_shift;
      pending_bits_next    = pend_sum;
      if (pend_sum >= 4'd8) begin
        pending_bits_next = pend_left;
        if (cap_hit) begin
          error_code_next = ST_OVER_CAP;
        end else begin
          res_valid          = 1'b1;
          res.out_byte       = byte_window[7:0];
          bytes_emitted_next = bytes_emitted + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= CAP_RESET;
      bit_accumulator <= '0;
      pending_bits    <= '0;
      bytes_emitted   <= '0;
      error_code      <= ST_OK;
      padding_seen    <= 1'b0;
      out_valid       <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        output_capacity <= cfg_data;
      end
      if (accept) begin
        bit_accumulator <= bit_accumulator_next;
        pending_bits    <= pending_bits_next;
        bytes_emitted   <= bytes_emitted_next;
        error_code      <= error_code_next;
        padding_seen    <= padding_seen_next;
      end
      if (out_valid && out_ready) begin
        if (skid_valid) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end else if (accept && res_valid) begin
          out_reg <= res;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (accept && res_valid) begin
        if (out_valid) begin
          skid_reg   <= res;
          skid_valid <= 1'b1;
        end else begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end
      end
    end
  end

  assign out_byte   = out_reg.out_byte;
  assign is_final   = out_reg.is_final;
  assign status     = out_reg.status;
  assign byte_count = out_reg.byte_count;

endmodule
